// ----- hw/rtl/bsm_pkg.sv -----
// shared widths, types and constants for the bounding sphere merge block
`default_nettype none
package bsm_pkg;
	localparam int unsigned COORD_W  = 32;
	localparam int unsigned RAD_W    = 31;
	localparam int unsigned MAG_W    = 33;
	localparam int unsigned OPND_W   = 34;
	localparam int unsigned PROD_W   = 68;
	localparam int unsigned REM_W    = 37;
	localparam int unsigned STEPS    = 34;
	localparam int unsigned CNT_W    = 6;

	typedef struct packed {
		logic                load;
		logic                sqrt_mode;
		logic                step;
		logic [PROD_W-1:0]   src;
		logic [REM_W-1:0]    rem;
		logic [OPND_W-1:0]   den;
	} iter_ctl_t;
endpackage
`default_nettype wire

// ----- hw/rtl/bsm_if.sv -----
// valid/ready channels for sphere input beats and bound output beats
`default_nettype none
interface bsm_in_if;
	import bsm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      first;
	logic signed [COORD_W-1:0] sphere_x;
	logic signed [COORD_W-1:0] sphere_y;
	logic signed [COORD_W-1:0] sphere_z;
	logic [RAD_W-1:0]          sphere_r;
	modport source (output valid, first, sphere_x, sphere_y, sphere_z, sphere_r, input ready);
	modport sink (input valid, first, sphere_x, sphere_y, sphere_z, sphere_r, output ready);
endinterface

interface bsm_out_if;
	import bsm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] bound_x;
	logic signed [COORD_W-1:0] bound_y;
	logic signed [COORD_W-1:0] bound_z;
	logic [RAD_W-1:0]          bound_radius;
	modport source (output valid, bound_x, bound_y, bound_z, bound_radius, input ready);
	modport sink (input valid, bound_x, bound_y, bound_z, bound_radius, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bsm_iter_unit.sv -----
// shared restoring digit unit: square root two bits a step, division one bit a step
`default_nettype none
module bsm_iter_unit
	import bsm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire iter_ctl_t         ctl,
	output logic [OPND_W-1:0]      acc
);
	logic [PROD_W-1:0] src_q;
	logic [REM_W-1:0]  rem_q;
	logic [OPND_W-1:0] acc_q;
	logic [REM_W-1:0]  shifted;
	logic [REM_W:0]    trial;
	logic [REM_W:0]    diff;
	logic              ge;

	always_comb begin
		if (ctl.sqrt_mode) begin
			shifted = {rem_q[REM_W-3:0], src_q[PROD_W-1 -: 2]};
			trial   = {{(REM_W-OPND_W-1){1'b0}}, acc_q, 2'b01};
		end else begin
			shifted = {rem_q[REM_W-2:0], src_q[PROD_W-1]};
			trial   = {{(REM_W-OPND_W+1){1'b0}}, ctl.den};
		end
		diff = {1'b0, shifted} - trial;
		ge   = !diff[REM_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.load) begin
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= {acc_q[OPND_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			src_q <= ctl.src;
			rem_q <= ctl.rem;
		end else if (ctl.step) begin
			src_q <= ctl.sqrt_mode ? {src_q[PROD_W-3:0], 2'b00} : {src_q[PROD_W-2:0], 1'b0};
			rem_q <= ge ? diff[REM_W-1:0] : shifted;
		end
	end

	assign acc = acc_q;
endmodule
`default_nettype wire

// ----- hw/rtl/bounding_sphere_merge.sv -----
// top level of the running bounding sphere merge
// One sphere beat is taken when the block is idle, and its bound is worked out
// in this order: the squared distance, 34 steps of the shared digit unit for
// the root, and per axis one multiply, one load and 34 division steps on the
// same unit; a first-flagged beat skips the root and the divisions, and a beat
// that leaves the center in place skips the divisions. The output register
// holds the bound until it is taken; the next beat may be taken meanwhile, but
// its bound waits until the register is free.
`default_nettype none
module bounding_sphere_merge
	import bsm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	bsm_in_if.sink     sphere_in,
	bsm_out_if.source  bound_out
);
	typedef enum logic [3:0] {IDLE, SQ, ROOT, DECIDE, MUL, DLOAD, DIV, APPLY, DONE} state_t;

	state_t                    state_q;
	logic [1:0]                ax_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      first_q;
	logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
	logic [RAD_W-1:0]          r_q;
	logic signed [COORD_W-1:0] kx_q, ky_q, kz_q;
	logic [RAD_W-1:0]          kr_q;
	logic [COORD_W-1:0]        nc_q [3];
	logic [PROD_W-1:0]         prod_q, sum_q;
	logic [OPND_W-1:0]         n_q, den_q;
	logic [RAD_W-1:0]          rad_q;
	logic                      ovalid_q;
	logic [COORD_W-1:0]        ox_q, oy_q, oz_q;
	logic [RAD_W-1:0]          or_q;

	logic [MAG_W-1:0]          dx, dy, dz, sel_d, sel_mag;
	logic [OPND_W-1:0]         mul_b, acc;
	logic [PROD_W-1:0]         prod, sum_next;
	logic [COORD_W-1:0]        sel_k, new_c;
	logic [OPND_W:0]           lr, lrr;
	logic [OPND_W:0]           lsum;
	iter_ctl_t                 ctl;

	assign dx = {kx_q[COORD_W-1], kx_q} - {cx_q[COORD_W-1], cx_q};
	assign dy = {ky_q[COORD_W-1], ky_q} - {cy_q[COORD_W-1], cy_q};
	assign dz = {kz_q[COORD_W-1], kz_q} - {cz_q[COORD_W-1], cz_q};

	always_comb begin
		case (ax_q)
			2'd0:    begin sel_d = dx; sel_k = kx_q; end
			2'd1:    begin sel_d = dy; sel_k = ky_q; end
			default: begin sel_d = dz; sel_k = kz_q; end
		endcase
		sel_mag  = sel_d[MAG_W-1] ? (~sel_d + 1'b1) : sel_d;
		mul_b    = (state_q == SQ) ? {1'b0, sel_mag} : n_q;
		prod     = PROD_W'({1'b0, sel_mag}) * PROD_W'(mul_b);
		sum_next = sum_q + prod_q;
		new_c    = sel_d[MAG_W-1] ? (sel_k + acc[COORD_W-1:0]) : (sel_k - acc[COORD_W-1:0]);
		lr       = {1'b0, acc} + (OPND_W+1)'(r_q);
		lrr      = {1'b0, acc} + (OPND_W+1)'(kr_q);
		lsum     = lr + (OPND_W+1)'(kr_q);
	end

	always_comb begin
		ctl           = '0;
		ctl.den       = den_q;
		ctl.sqrt_mode = (state_q == SQ) || (state_q == ROOT);
		if (state_q == SQ && ax_q == 2'd3) begin
			ctl.load = 1'b1;
			ctl.src  = sum_next;
		end
		if (state_q == DLOAD) begin
			ctl.load = 1'b1;
			ctl.src  = {prod_q[OPND_W-1:0], {(PROD_W-OPND_W){1'b0}}};
			ctl.rem  = REM_W'(prod_q[PROD_W-1:OPND_W]);
		end
		ctl.step = (state_q == ROOT) || (state_q == DIV);
	end

	bsm_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			ax_q     <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
			kx_q     <= '0;
			ky_q     <= '0;
			kz_q     <= '0;
			kr_q     <= '0;
		end else begin
			if (state_q == DONE && (!ovalid_q || bound_out.ready)) begin
				ovalid_q <= 1'b1;
			end else if (bound_out.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (sphere_in.valid) begin
						state_q <= SQ;
						ax_q    <= '0;
					end
				end
				SQ: begin
					if (first_q) begin
						kx_q    <= cx_q;
						ky_q    <= cy_q;
						kz_q    <= cz_q;
						kr_q    <= r_q;
						state_q <= DONE;
					end else begin
						ax_q <= ax_q + 2'd1;
						if (ax_q == 2'd3) begin
							state_q <= ROOT;
							cnt_q   <= '0;
						end
					end
				end
				ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(STEPS-1)) state_q <= DECIDE;
				end
				DECIDE: begin
					ax_q <= '0;
					if (acc != '0 && lr > (OPND_W+1)'(kr_q)
							&& (OPND_W+1)'(r_q) > lrr) begin
						kx_q    <= cx_q;
						ky_q    <= cy_q;
						kz_q    <= cz_q;
						kr_q    <= r_q;
						state_q <= DONE;
					end else if (acc == '0) begin
						if (r_q > kr_q) kr_q <= r_q;
						state_q <= DONE;
					end else if (lr > (OPND_W+1)'(kr_q)) begin
						state_q <= MUL;
					end else begin
						state_q <= DONE;
					end
				end
				MUL: state_q <= DLOAD;
				DLOAD: begin
					state_q <= DIV;
					cnt_q   <= '0;
				end
				DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(STEPS-1)) state_q <= APPLY;
				end
				APPLY: begin
					ax_q <= ax_q + 2'd1;
					if (ax_q == 2'd2) begin
						kx_q    <= nc_q[0];
						ky_q    <= nc_q[1];
						kz_q    <= new_c;
						kr_q    <= rad_q;
						state_q <= DONE;
					end else begin
						state_q <= MUL;
					end
				end
				DONE: begin
					if (!ovalid_q || bound_out.ready) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && sphere_in.valid) begin
			first_q <= sphere_in.first;
			cx_q    <= sphere_in.sphere_x;
			cy_q    <= sphere_in.sphere_y;
			cz_q    <= sphere_in.sphere_z;
			r_q     <= sphere_in.sphere_r;
			sum_q   <= '0;
		end
		if (state_q == SQ) begin
			prod_q <= prod;
			if (ax_q != 2'd0) sum_q <= sum_next;
		end
		if (state_q == DECIDE) begin
			n_q   <= OPND_W'(lr - (OPND_W+1)'(kr_q));
			den_q <= {acc[OPND_W-2:0], 1'b0};
			rad_q <= (lsum[OPND_W:1] > (OPND_W)'({RAD_W{1'b1}})) ? {RAD_W{1'b1}}
				: lsum[RAD_W:1];
		end
		if (state_q == MUL) prod_q <= prod;
		if (state_q == APPLY) nc_q[ax_q] <= new_c;
		if (state_q == DONE && (!ovalid_q || bound_out.ready)) begin
			ox_q <= kx_q;
			oy_q <= ky_q;
			oz_q <= kz_q;
			or_q <= kr_q;
		end
	end

	assign sphere_in.ready        = (state_q == IDLE);
	assign bound_out.valid        = ovalid_q;
	assign bound_out.bound_x      = ox_q;
	assign bound_out.bound_y      = oy_q;
	assign bound_out.bound_z      = oz_q;
	assign bound_out.bound_radius = or_q;

`ifndef SYNTHESIS
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		sphere_in.valid && sphere_in.ready |=> !sphere_in.ready)
		else $error("accepted a beat while busy");
	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STEPS))
		else $error("digit step count overran");
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(bound_out.valid) |-> !$past(sphere_in.ready))
		else $error("result without work");
`endif
endmodule
`default_nettype wire
